// ----- hw/rtl/mhpf_pkg.sv -----
`default_nettype none

package mhpf_pkg;

  // Result item layout, 186 used bits padded to whole bytes
  localparam int OUT_W = 192;
  localparam int PAD_W = 6;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_TRUNC    = 3'd1;
  localparam status_t ST_SECURITY = 3'd2;
  localparam status_t ST_ACK_ADDR = 3'd3;
  localparam status_t ST_NO_FCS   = 3'd4;
  localparam status_t ST_BAD_TYPE = 3'd5;

  // Destination class codes
  typedef logic [1:0] class_t;
  localparam class_t CLS_HOST  = 2'd0;
  localparam class_t CLS_BCAST = 2'd1;
  localparam class_t CLS_OTHER = 2'd2;

  // Address modes (mode 1 is reserved and handled as long)
  typedef logic [1:0] amode_t;
  localparam amode_t AM_NONE  = 2'd0;
  localparam amode_t AM_SHORT = 2'd2;

  // Frame types
  typedef logic [2:0] ftype_t;
  localparam ftype_t FT_ACK     = 3'd2;
  localparam ftype_t FT_LAST_OK = 3'd3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FCS_PRESENT = 2'd0;
  localparam cfg_idx_t CFG_OWN_PAN     = 2'd1;
  localparam cfg_idx_t CFG_OWN_SHORT   = 2'd2;
  localparam cfg_idx_t CFG_OWN_LONG    = 2'd3;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [4:0]       header_length;
    class_t           packet_class;
    logic [63:0]      src_address;
    logic [15:0]      src_pan;
    amode_t           src_mode;
    logic [63:0]      dst_address;
    logic [15:0]      dst_pan;
    amode_t           dst_mode;
    logic [7:0]       sequence_res;
    logic             ack_wanted;
    ftype_t           frame_kind;
    status_t          status;
  } result_t;

  // Address field length in bytes for a given mode
  function automatic logic [3:0] mode_addr_bytes(input amode_t mode);
    if (mode == AM_NONE) begin
      return 4'd0;
    end else if (mode == AM_SHORT) begin
      return 4'd2;
    end else begin
      return 4'd8;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mac_rx_header_parse_filter_unit.sv -----
// 802.15.4 receive header parser and address filter.
// Input channel (in_*): one frame byte per item in in_tdata, in_tlast set on
// the final byte of a frame. Result channel (out_*): one item per frame,
// issued for the byte that carries in_tlast, holding status, decoded header
// fields and the destination class (see mhpf_pkg::result_t for the layout).
// Configuration (cfg_*): write-only registers indexed as mhpf_pkg CFG_*,
// written at any edge with cfg_we high; change them only while no frame is
// in flight.
// Throughput: one byte per cycle while in_tready is high. A byte is captured
// in an input register, then decoded into the header state, and a frame's
// result is loaded into the result register as its last byte is decoded.
// When the receiver stalls, the result register holds; bytes that do not
// end a frame keep flowing, and in_tready drops only when a last byte waits
// for the result register to free up.
// Reset (rst_n low, synchronous) empties both registers, clears the frame
// state and loads the register defaults (FCS present, PAN and short address
// 0xffff, long address zero).
`default_nettype none

module mac_rx_header_parse_filter_unit #(
  parameter int MAX_FRAME_BYTES = 127
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // in_tdata: frame_byte[7:0]
  input  wire logic [7:0]                in_tdata,
  input  wire logic                      in_tlast,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // out_tdata: status[2:0], frame_kind[5:3], ack_wanted[6], sequence_res[14:7],
  // dst_mode[16:15], dst_pan[32:17], dst_address[96:33], src_mode[98:97],
  // src_pan[114:99], src_address[178:115], packet_class[180:179],
  // header_length[185:181], zero[191:186]
  output logic [mhpf_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_we,
  input  wire mhpf_pkg::cfg_idx_t        cfg_index,
  input  wire logic [63:0]               cfg_wdata
);
  import mhpf_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW    = (POS_W > 5) ? POS_W : 5;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  // Configuration registers
  logic        fcs_present_r;
  logic [15:0] own_pan_id_r;
  logic [15:0] own_short_addr_r;
  logic [63:0] own_long_addr_r;

  // Input register
  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Frame state
  logic [POS_W-1:0] pos_r, pos_upd, pos_nxt;
  logic [15:0]      fc_r, fc_upd, fc_nxt;
  logic [7:0]       seq_r, seq_upd, seq_nxt;
  logic [15:0]      dpan_r, dpan_upd, dpan_nxt;
  logic [63:0]      daddr_r, daddr_upd, daddr_nxt;
  logic [15:0]      span_r, span_upd, span_nxt;
  logic [63:0]      saddr_r, saddr_upd, saddr_nxt;
  status_t          err_r, err_upd, err_nxt;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  result_t res;

  logic proc;
  logic place;
  logic done;

  // Decode of the current frame control word for byte placement
  amode_t        dmode, smode;
  logic          intra;
  logic [LW-1:0] p, dlen, slen, spanlen, d_end, s_base, sp_end, sa_end;
  logic [LW-1:0] off;

  // Result side
  amode_t        r_dmode, r_smode;
  logic          r_intra;
  ftype_t        r_kind;
  logic [4:0]    hl;
  logic [LW-1:0] len, hl_w;
  status_t       st;
  class_t        cls;

  // Handshake: a byte moves on unless it ends a frame and the result is blocked
  assign proc      = vld_r && (!last_r || !out_valid_r || out_tready);
  assign in_tready = !vld_r || proc;
  assign place     = proc && (pos_r < POS_MAX);
  assign done      = proc && last_r;

  assign dmode   = amode_t'(fc_r[11:10]);
  assign smode   = amode_t'(fc_r[15:14]);
  assign intra   = fc_r[6];
  assign p       = LW'(pos_r);
  assign dlen    = LW'(mode_addr_bytes(dmode));
  assign slen    = LW'(mode_addr_bytes(smode));
  assign spanlen = (smode != AM_NONE && !intra) ? LW'(2) : LW'(0);
  assign d_end   = LW'(5) + dlen;
  assign s_base  = (dmode != AM_NONE) ? d_end : LW'(3);
  assign sp_end  = s_base + spanlen;
  assign sa_end  = sp_end + slen;

  // Byte placement into the header fields
  always_comb begin
    pos_upd   = pos_r;
    fc_upd    = fc_r;
    seq_upd   = seq_r;
    dpan_upd  = dpan_r;
    daddr_upd = daddr_r;
    span_upd  = span_r;
    saddr_upd = saddr_r;
    err_upd   = err_r;
    off       = '0;
    if (place) begin
      pos_upd = pos_r + POS_W'(1);
      if (p == LW'(0)) begin
        fc_upd[7:0] = byte_r;
      end else if (p == LW'(1)) begin
        fc_upd[15:8] = byte_r;
        if (fc_r[3]) begin
          err_upd = ST_SECURITY;
        end else if (fc_r[2:0] == FT_ACK && (amode_t'(byte_r[3:2]) != AM_NONE ||
                                             amode_t'(byte_r[7:6]) != AM_NONE)) begin
          err_upd = ST_ACK_ADDR;
        end
      end else if (p == LW'(2)) begin
        seq_upd = byte_r;
      end else if (dmode != AM_NONE && p < LW'(5)) begin
        off = p - LW'(3);
        dpan_upd[{off[0], 3'b000} +: 8] = byte_r;
      end else if (dmode != AM_NONE && p < d_end) begin
        off = p - LW'(5);
        daddr_upd[{off[2:0], 3'b000} +: 8] = byte_r;
      end else if (p < sp_end) begin
        off = p - s_base;
        span_upd[{off[0], 3'b000} +: 8] = byte_r;
      end else if (p < sa_end) begin
        off = p - sp_end;
        saddr_upd[{off[2:0], 3'b000} +: 8] = byte_r;
      end
    end
  end

  // State returns to zero once a frame has been reported
  always_comb begin
    pos_nxt   = done ? '0 : pos_upd;
    fc_nxt    = done ? '0 : fc_upd;
    seq_nxt   = done ? '0 : seq_upd;
    dpan_nxt  = done ? '0 : dpan_upd;
    daddr_nxt = done ? '0 : daddr_upd;
    span_nxt  = done ? '0 : span_upd;
    saddr_nxt = done ? '0 : saddr_upd;
    err_nxt   = done ? ST_OK : err_upd;
  end

  // Header length and status from the completed frame
  assign r_dmode = amode_t'(fc_upd[11:10]);
  assign r_smode = amode_t'(fc_upd[15:14]);
  assign r_intra = fc_upd[6];
  assign r_kind  = ftype_t'(fc_upd[2:0]);
  assign len     = LW'(pos_upd);
  assign hl_w    = LW'(hl);

  always_comb begin
    hl = 5'd3;
    if (r_dmode != AM_NONE) begin
      hl = hl + 5'd2 + 5'(mode_addr_bytes(r_dmode));
    end
    if (r_smode != AM_NONE) begin
      hl = hl + (r_intra ? 5'd0 : 5'd2) + 5'(mode_addr_bytes(r_smode));
    end
  end

  always_comb begin
    if (len < LW'(3)) begin
      st = ST_TRUNC;
    end else if (err_upd != ST_OK) begin
      st = err_upd;
    end else if (len < hl_w) begin
      st = ST_TRUNC;
    end else if (fcs_present_r && (len < hl_w + LW'(2))) begin
      st = ST_NO_FCS;
    end else if (r_kind > FT_LAST_OK) begin
      st = ST_BAD_TYPE;
    end else begin
      st = ST_OK;
    end
  end

  // Destination class against own addresses
  always_comb begin
    if (r_dmode == AM_NONE) begin
      cls = (r_smode != AM_NONE) ? CLS_OTHER : CLS_HOST;
    end else if (dpan_upd != own_pan_id_r && dpan_upd != 16'hffff) begin
      cls = CLS_OTHER;
    end else if (r_dmode == AM_SHORT) begin
      if (daddr_upd == {48'd0, own_short_addr_r}) begin
        cls = CLS_HOST;
      end else if (daddr_upd == 64'h0000_0000_0000_ffff) begin
        cls = CLS_BCAST;
      end else begin
        cls = CLS_OTHER;
      end
    end else begin
      if (daddr_upd == own_long_addr_r) begin
        cls = CLS_HOST;
      end else if (daddr_upd == '1) begin
        cls = CLS_BCAST;
      end else begin
        cls = CLS_OTHER;
      end
    end
  end

  // Result assembly; statuses other than OK and BAD_TYPE carry only the status
  always_comb begin
    res        = '0;
    res.status = st;
    if (st == ST_OK || st == ST_BAD_TYPE) begin
      res.frame_kind    = r_kind;
      res.ack_wanted    = fc_upd[5];
      res.sequence_res  = seq_upd;
      res.dst_mode      = r_dmode;
      res.dst_pan       = dpan_upd;
      res.dst_address   = daddr_upd;
      res.src_mode      = r_smode;
      res.src_pan       = r_intra ? dpan_upd : span_upd;
      res.src_address   = saddr_upd;
      res.packet_class  = cls;
      res.header_length = hl;
    end
  end

  // Result register valid
  always_comb begin
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      fc_r        <= '0;
      seq_r       <= '0;
      dpan_r      <= '0;
      daddr_r     <= '0;
      span_r      <= '0;
      saddr_r     <= '0;
      err_r       <= ST_OK;
    end else begin
      if (in_tready) begin
        vld_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      fc_r        <= fc_nxt;
      seq_r       <= seq_nxt;
      dpan_r      <= dpan_nxt;
      daddr_r     <= daddr_nxt;
      span_r      <= span_nxt;
      saddr_r     <= saddr_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (done) begin
      out_r <= res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_present_r    <= 1'b1;
      own_pan_id_r     <= 16'hffff;
      own_short_addr_r <= 16'hffff;
      own_long_addr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FCS_PRESENT: fcs_present_r    <= cfg_wdata[0];
        CFG_OWN_PAN:     own_pan_id_r     <= cfg_wdata[15:0];
        CFG_OWN_SHORT:   own_short_addr_r <= cfg_wdata[15:0];
        CFG_OWN_LONG:    own_long_addr_r  <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mhpf_checker.sv -----
`default_nettype none

module mhpf_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic [mhpf_pkg::OUT_W-1:0] out_tdata,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready
);
  import mhpf_pkg::*;

  result_t res;
  assign res = out_tdata;

  // A stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Status and class stay within their codes
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.status <= ST_BAD_TYPE && res.packet_class <= CLS_OTHER)
    else $error("status or class out of range");

  // Error results carry nothing but the status
  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status == ST_TRUNC || res.status == ST_SECURITY ||
                   res.status == ST_ACK_ADDR || res.status == ST_NO_FCS)
    |-> out_tdata[OUT_W-1:3] == '0)
    else $error("error result with fields set");

  // Reported header length is a legal header size
  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status == ST_OK || res.status == ST_BAD_TYPE)
    |-> res.header_length >= 5'd3 && res.header_length <= 5'd23)
    else $error("header length out of range");

endmodule

bind mac_rx_header_parse_filter_unit mhpf_checker u_mhpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
